// ===== src/psgr_pkg.sv =====
// Shared types, codes and arithmetic helpers for the stereo gain ramp.
`default_nettype none
package psgr_pkg;

	localparam int unsigned IDX_W    = 6;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned GAIN_W   = 16;

	localparam logic [GAIN_W-1:0] RAMP_STEP_RESET = 16'd14;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_NULL   = 2'd2
	} psgr_kind_t;

	typedef struct packed {
		psgr_kind_t                 kind;
		logic [IDX_W-1:0]           idx;
		logic signed [SAMPLE_W-1:0] sample;
		logic [GAIN_W-1:0]          target_left;
		logic [GAIN_W-1:0]          target_right;
		logic                       last;
	} psgr_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0] left;
		logic [GAIN_W-1:0] right;
	} psgr_gain_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		psgr_gain_t       gain;
	} psgr_wr_t;

	// Sample times unsigned gain, floor shift by 15, saturate to 16 bits.
	function automatic logic signed [SAMPLE_W-1:0] scale_sample(
		input logic signed [SAMPLE_W-1:0] s,
		input logic [GAIN_W-1:0]          g
	);
		logic signed [32:0] p;
		logic signed [17:0] q;
		logic signed [SAMPLE_W-1:0] r;
		p = 33'(s) * $signed({1'b0, g});
		q = p[32:15];
		if (q > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (q < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = q[15:0];
		end
		return r;
	endfunction

	// Move one step toward the target, only when a full step remains.
	function automatic logic [GAIN_W-1:0] ramp_toward(
		input logic [GAIN_W-1:0] g,
		input logic [GAIN_W-1:0] t,
		input logic [GAIN_W-1:0] step
	);
		logic [GAIN_W-1:0] diff;
		logic [GAIN_W-1:0] r;
		r    = g;
		diff = '0;
		if (step != '0) begin
			if (t > g) begin
				diff = t - g;
				if (diff >= step) r = g + step;
			end else begin
				diff = g - t;
				if (diff >= step) r = g - step;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/per_source_stereo_gain_ramp.sv =====
// Top level: mono to stereo with a ramped left/right gain for each source.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid/in_ready, opcode, source_index,       | input beat
//           | sample, target_left, target_right, last_frame  |
//   out     | out_valid/out_ready, left_sample,              | result beat
//           | right_sample, frame_end                        |
//   cfg     | cfg_valid/cfg_ready, ramp_step                 | register write
//
// Throughput is one input beat per cycle while the output is not stalled; the gain
// read-modify-write closes in a single back-end stage, with a bypass from the write
// to the next read. A sample beat passes the queue and the gain read stage, then its
// result is registered in the output register. Clear beats produce nothing.
// Reset zeroes the per-source valid bits, so every gain reads as zero with no
// clearing pass; ramp_step returns to 14. A stalled output holds the back end
// while the two-entry queue keeps taking input beats until it fills.
`default_nettype none
module per_source_stereo_gain_ramp import psgr_pkg::*; #(
	parameter int unsigned SOURCE_COUNT = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       opcode,
	input  wire logic [IDX_W-1:0]           source_index,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic [GAIN_W-1:0]          target_left,
	input  wire logic [GAIN_W-1:0]          target_right,
	input  wire logic                       last_frame,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      left_sample,
	output logic signed [SAMPLE_W-1:0]      right_sample,
	output logic                            frame_end,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [GAIN_W-1:0]          ramp_step
);

	logic              cfg_fire;
	logic [GAIN_W-1:0] step_q;
	logic              q_valid;
	logic              q_pop;
	psgr_item_t        q_item;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx;
	psgr_gain_t        rd_gain;
	psgr_wr_t          wr;

	// Always taken; user must have config writes only arrive while block is idle.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= RAMP_STEP_RESET;
		end else if (cfg_fire && cfg_ready) begin
			step_q <= ramp_step;
		end
	end

	// Front: accept and classify, queue up to two beats.
	psgr_front #(
		.SOURCE_COUNT(SOURCE_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.source_index (source_index),
		.sample       (sample),
		.target_left  (target_left),
		.target_right (target_right),
		.last_frame   (last_frame),
		.q_pop        (q_pop),
		.q_valid      (q_valid),
		.q_item       (q_item)
	);

	// Gain store: read on pop, written by the back end when the popped beat fires.
	psgr_gain_mem #(
		.SOURCE_COUNT(SOURCE_COUNT)
	) u_gain_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.wr      (wr),
		.rd_gain (rd_gain)
	);

	// Back: scale, ramp, write back, register the result beat.
	psgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.ramp_step    (step_q),
		.rd_en        (rd_en),
		.rd_idx       (rd_idx),
		.rd_gain      (rd_gain),
		.wr           (wr),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.frame_end    (frame_end)
	);

endmodule
`default_nettype wire

// ===== src/psgr_front.sv =====
// Front end: accept input beats, classify them and queue them for the back end.
`default_nettype none
module psgr_front import psgr_pkg::*; #(
	parameter int unsigned SOURCE_COUNT = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       opcode,
	input  wire logic [IDX_W-1:0]           source_index,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic [GAIN_W-1:0]          target_left,
	input  wire logic [GAIN_W-1:0]          target_right,
	input  wire logic                       last_frame,
	input  wire logic                       q_pop,
	output logic                            q_valid,
	output psgr_item_t                      q_item
);

	psgr_item_t fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	logic       in_range;
	logic       push;
	psgr_item_t item;

	assign in_range = 32'(source_index) < SOURCE_COUNT;

	// Classify; a clear of an unknown source is dropped here.
	always_comb begin
		item.idx          = source_index;
		item.sample       = sample;
		item.target_left  = target_left;
		item.target_right = target_right;
		item.last         = last_frame;
		if (opcode == OP_CLEAR) begin
			item.kind = KIND_CLEAR;
		end else if (in_range) begin
			item.kind = KIND_SAMPLE;
		end else begin
			item.kind = KIND_NULL;
		end
	end

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready && !(opcode == OP_CLEAR && !in_range);
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/psgr_gain_mem.sv =====
// Per-source left/right gain memory with valid bits and write-to-read bypass.
`default_nettype none
module psgr_gain_mem import psgr_pkg::*; #(
	parameter int unsigned SOURCE_COUNT = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_idx,
	input  wire psgr_wr_t         wr,
	output psgr_gain_t            rd_gain
);

	localparam int unsigned DEPTH = (SOURCE_COUNT < (2 ** IDX_W)) ? SOURCE_COUNT : (2 ** IDX_W);
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	psgr_gain_t       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	psgr_gain_t       mem_rd_s2;
	psgr_gain_t       byp_s2;
	logic             hit_s2;
	logic             vld_s2;
	logic [AW-1:0]    ra;
	logic [AW-1:0]    wa;

	assign ra = rd_idx[AW-1:0];
	assign wa = wr.idx[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) mem[wa] <= wr.gain;
		if (rd_en) begin
			mem_rd_s2 <= mem[ra];
			byp_s2    <= wr.gain;
		end
	end

	// Entries never written read as zero gain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s2  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			if (wr.en) valid_q[wa] <= 1'b1;
			if (rd_en) begin
				hit_s2 <= wr.en && (wa == ra);
				vld_s2 <= valid_q[ra];
			end
		end
	end

	assign rd_gain = hit_s2 ? byp_s2 : (vld_s2 ? mem_rd_s2 : '0);

endmodule
`default_nettype wire

// ===== src/psgr_back.sv =====
// Back end: scale the sample by stored gains, ramp the gains (or zero them on a clear), drive the result.
`default_nettype none
module psgr_back import psgr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire psgr_item_t           q_item,
	output logic                      q_pop,
	input  wire logic [GAIN_W-1:0]    ramp_step,
	output logic                      rd_en,
	output logic [IDX_W-1:0]          rd_idx,
	input  wire psgr_gain_t           rd_gain,
	output psgr_wr_t                  wr,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [SAMPLE_W-1:0] left_sample,
	output logic signed [SAMPLE_W-1:0] right_sample,
	output logic                      frame_end
);

	psgr_item_t                 item_s2;
	logic                       valid_s2;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                       frame_end_q;

	logic                       out_free;
	logic                       fire_s2;
	logic                       emit;
	logic signed [SAMPLE_W-1:0] left_res;
	logic signed [SAMPLE_W-1:0] right_res;

	assign out_free = !out_valid_q || out_ready;
	assign fire_s2  = valid_s2 && (item_s2.kind == KIND_CLEAR || out_free);
	assign emit     = fire_s2 && item_s2.kind != KIND_CLEAR;
	assign q_pop    = q_valid && (!valid_s2 || fire_s2);
	assign rd_en    = q_pop;
	assign rd_idx   = q_item.idx;

	always_comb begin
		wr.idx   = item_s2.idx;
		wr.en    = 1'b0;
		wr.gain  = '0;
		left_res  = '0;
		right_res = '0;
		case (item_s2.kind)
			KIND_SAMPLE: begin
				left_res        = scale_sample(item_s2.sample, rd_gain.left);
				right_res       = scale_sample(item_s2.sample, rd_gain.right);
				wr.en           = fire_s2;
				wr.gain.left    = ramp_toward(rd_gain.left, item_s2.target_left, ramp_step);
				wr.gain.right   = ramp_toward(rd_gain.right, item_s2.target_right, ramp_step);
			end
			KIND_CLEAR: begin
				wr.en = fire_s2;
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_s2 <= q_item;
		if (emit) begin
			left_q      <= left_res;
			right_q     <= right_res;
			frame_end_q <= item_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s2 <= 1'b1;
			end else if (fire_s2) begin
				valid_s2 <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign frame_end    = frame_end_q;

endmodule
`default_nettype wire
